// ===== rtl/core/sif_pkg.sv =====
// ----------------------------------------------------------------------------
// sif_pkg
// Shared types and constants of the segment intersection filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sif_pkg;

   // Width of each output coordinate, signed fixed point.
   localparam int OUT_BITS = 28;

   // Result data bus: cross_x then cross_y, padded to whole bytes.
   localparam int RSP_DATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

   // Defaults for the top-level parameters.
   localparam int COORD_BITS_DEF = 20;
   localparam int FRAC_BITS_DEF  = 8;

   // Configuration register index.
   localparam int CSR_AW = 3;

   typedef enum logic [CSR_AW-1:0] {
      CSR_QUERY_START_X = 3'd0,
      CSR_QUERY_START_Y = 3'd1,
      CSR_QUERY_END_X   = 3'd2,
      CSR_QUERY_END_Y   = 3'd3,
      CSR_QUERY_ON_TOP  = 3'd4
   } csr_idx_type;

   // Control that travels with each item through the pipeline.
   typedef struct packed {
      logic valid;
      logic hit;
      logic neg_x;
      logic neg_y;
   } sif_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/sif_front.sv =====
// ----------------------------------------------------------------------------
// sif_front
// Determinant, hit test and dividend setup ahead of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sif_front #(
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic signed [COORD_BITS-1:0]   zsx,
   input  wire logic signed [COORD_BITS-1:0]   zsy,
   input  wire logic signed [COORD_BITS-1:0]   zex,
   input  wire logic signed [COORD_BITS-1:0]   zey,
   input  wire logic                           zone_top,
   input  wire logic signed [COORD_BITS-1:0]   qsx,
   input  wire logic signed [COORD_BITS-1:0]   qsy,
   input  wire logic signed [COORD_BITS-1:0]   qex,
   input  wire logic signed [COORD_BITS-1:0]   qey,
   input  wire logic                           query_top,
   output sif_pkg::sif_ctl_type                ctl_out,
   output logic [2*COORD_BITS+1:0]             den_out,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]   wx_out,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]   wy_out
);
   import sif_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int DB = 2 * COORD_BITS + 2;
   localparam int H  = (DB + 1) / 2;
   localparam int HB = DB - H;
   localparam int NB = 3 * COORD_BITS + 3;
   localparam int WW = NB + FRAC_BITS;

   // Stage 1: differences.
   logic              v1_ff, side1_ff;
   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, wx_ff, wy_ff;
   // Stage 2: cross products.
   logic              v2_ff, side2_ff;
   logic signed [DW-1:0] d1x2_ff, d1y2_ff;
   logic signed [PW-1:0] pd1_ff, pd2_ff, pt1_ff, pt2_ff, pu1_ff, pu2_ff;
   // Stage 3: determinant and numerators.
   logic              v3_ff, side3_ff;
   logic signed [DW-1:0] d1x3_ff, d1y3_ff;
   logic signed [SW-1:0] den3_ff, tn3_ff, un3_ff;
   // Stage 4: normalized and tested.
   logic              v4_ff, hit4_ff;
   logic signed [DW-1:0] d1x4_ff, d1y4_ff;
   logic [DB-1:0]     den4_ff, tn4_ff;
   logic signed [SW-1:0] den_a, tn_a, un_a;
   logic              hit4_in;
   // Stage 5: partial products.
   logic              v5_ff, hit5_ff;
   logic [DB-1:0]     den5_ff;
   logic signed [COORD_BITS+H:0]  pblx_ff, pbly_ff;
   logic signed [COORD_BITS+HB:0] pbhx_ff, pbhy_ff;
   logic signed [DW+H:0]          tplx_ff, tply_ff;
   logic signed [DW+HB:0]         tphx_ff, tphy_ff;
   // Stage 6: numerators of the coordinates.
   logic              v6_ff, hit6_ff;
   logic [DB-1:0]     den6_ff;
   logic signed [NB-1:0] nx_ff, ny_ff;
   // Stage 7: sign and magnitude, handed to the chain.
   logic [NB-1:0]     magx, magy;
   logic              v7_ff, hit7_ff, negx7_ff, negy7_ff;

   // Sign-normalize the determinant and test both parameters in [0, 1].
   always_comb begin
      den_a   = den3_ff[SW-1] ? -den3_ff : den3_ff;
      tn_a    = den3_ff[SW-1] ? -tn3_ff  : tn3_ff;
      un_a    = den3_ff[SW-1] ? -un3_ff  : un3_ff;
      hit4_in = side3_ff && (den3_ff != '0) && !tn_a[SW-1] && (tn_a <= den_a)
                && !un_a[SW-1] && (un_a <= den_a);
   end

   assign magx = nx_ff[NB-1] ? NB'(-nx_ff) : NB'(nx_ff);
   assign magy = ny_ff[NB-1] ? NB'(-ny_ff) : NB'(ny_ff);

   // Control handed to the first divider cell.
   assign ctl_out = '{valid: v7_ff, hit: hit7_ff, neg_x: negx7_ff, neg_y: negy7_ff};

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Datapath of the front stages.
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= (zone_top == query_top);
         d1x_ff   <= DW'(qex) - DW'(qsx);
         d1y_ff   <= DW'(qey) - DW'(qsy);
         d2x_ff   <= DW'(zex) - DW'(zsx);
         d2y_ff   <= DW'(zey) - DW'(zsy);
         wx_ff    <= DW'(zsx) - DW'(qsx);
         wy_ff    <= DW'(zsy) - DW'(qsy);

         side2_ff <= side1_ff;
         d1x2_ff  <= d1x_ff;
         d1y2_ff  <= d1y_ff;
         pd1_ff   <= d1x_ff * d2y_ff;
         pd2_ff   <= d1y_ff * d2x_ff;
         pt1_ff   <= wx_ff * d2y_ff;
         pt2_ff   <= wy_ff * d2x_ff;
         pu1_ff   <= wx_ff * d1y_ff;
         pu2_ff   <= wy_ff * d1x_ff;

         side3_ff <= side2_ff;
         d1x3_ff  <= d1x2_ff;
         d1y3_ff  <= d1y2_ff;
         den3_ff  <= SW'(pd1_ff) - SW'(pd2_ff);
         tn3_ff   <= SW'(pt1_ff) - SW'(pt2_ff);
         un3_ff   <= SW'(pu1_ff) - SW'(pu2_ff);

         hit4_ff  <= hit4_in;
         d1x4_ff  <= d1x3_ff;
         d1y4_ff  <= d1y3_ff;
         den4_ff  <= den_a[DB-1:0];
         tn4_ff   <= tn_a[DB-1:0];

         // Split the wide factors so each multiplier stays narrow.
         hit5_ff  <= hit4_ff;
         den5_ff  <= den4_ff;
         pblx_ff  <= qsx * $signed({1'b0, den4_ff[H-1:0]});
         pbly_ff  <= qsy * $signed({1'b0, den4_ff[H-1:0]});
         pbhx_ff  <= qsx * $signed({1'b0, den4_ff[DB-1:H]});
         pbhy_ff  <= qsy * $signed({1'b0, den4_ff[DB-1:H]});
         tplx_ff  <= d1x4_ff * $signed({1'b0, tn4_ff[H-1:0]});
         tply_ff  <= d1y4_ff * $signed({1'b0, tn4_ff[H-1:0]});
         tphx_ff  <= d1x4_ff * $signed({1'b0, tn4_ff[DB-1:H]});
         tphy_ff  <= d1y4_ff * $signed({1'b0, tn4_ff[DB-1:H]});

         hit6_ff  <= hit5_ff;
         den6_ff  <= den5_ff;
         nx_ff    <= (NB'(pbhx_ff) <<< H) + NB'(pblx_ff)
                     + (NB'(tphx_ff) <<< H) + NB'(tplx_ff);
         ny_ff    <= (NB'(pbhy_ff) <<< H) + NB'(pbly_ff)
                     + (NB'(tphy_ff) <<< H) + NB'(tply_ff);

         hit7_ff  <= hit6_ff;
         negx7_ff <= nx_ff[NB-1];
         negy7_ff <= ny_ff[NB-1];
         den_out  <= den6_ff;
         wx_out   <= WW'(magx) << FRAC_BITS;
         wy_out   <= WW'(magy) << FRAC_BITS;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sif_div_cell.sv =====
// ----------------------------------------------------------------------------
// sif_div_cell
// One cell of the divider chain: one restoring step for both coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module sif_div_cell #(
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  sif_pkg::sif_ctl_type                ctl_in,
   input  wire logic [2*COORD_BITS+1:0]        den_in,
   input  wire logic [3*COORD_BITS+FRAC_BITS+2:0] wx_in,
   input  wire logic [3*COORD_BITS+FRAC_BITS+2:0] wy_in,
   output sif_pkg::sif_ctl_type                ctl_out,
   output logic [2*COORD_BITS+1:0]             den_out,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]   wx_out,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]   wy_out
);
   import sif_pkg::*;

   localparam int DB = 2 * COORD_BITS + 2;
   localparam int QB = COORD_BITS + FRAC_BITS + 1;
   localparam int WW = DB + QB;

   // The word holds the partial remainder above and dividend or quotient
   // bits below; each step shifts one dividend bit into the remainder and
   // one quotient bit in at the bottom.
   function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
                                             input logic [DB-1:0] d);
      logic [WW:0] sh;
      logic [DB:0] top;
      logic [DB:0] diff;
      sh   = {w, 1'b0};
      top  = sh[WW:QB];
      diff = top - {1'b0, d};
      if (top >= {1'b0, d}) begin
         div_step = {diff[DB-1:0], sh[QB-1:1], 1'b1};
      end else begin
         div_step = {top[DB-1:0], sh[QB-1:0]};
      end
   endfunction

   // Step both coordinates and pass the control and divisor on; only the
   // valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_out.valid <= 1'b0;
      end else if (en) begin
         ctl_out <= ctl_in;
         den_out <= den_in;
         wx_out  <= div_step(wx_in, den_in);
         wy_out  <= div_step(wy_in, den_in);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/segment_intersection_filter_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_filter_unit
// Tests streamed zone segments against a query segment held in registers.
// ----------------------------------------------------------------------------
// Usage: write the query segment and its board side through the csr_ port
// while the block is idle. Zone segments then arrive on the req_ channel, one
// per transfer, and each produces exactly one transfer on the rsp_ channel,
// in order. rsp_tuser carries the hit flag; on a hit rsp_tdata carries the
// crossing point in signed fixed point with FRAC_BITS fraction bits, and it
// is all zeros otherwise.
// Throughput is one segment per cycle while the receiver does not hold off.
// The pipeline holds seven front stages for the differences, cross
// products, hit test and dividend setup, one divider cell per quotient
// bit, and the output register.
// The whole pipeline advances together; when the receiver holds off with a
// result waiting, req_tready falls in the same cycle and every stage holds.
// Reset clears the query registers to zero and empties the pipeline; it is
// synchronous and active high.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_filter_unit #(
   parameter int COORD_BITS = sif_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sif_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // Zone segment: zone_start_x, zone_start_y, zone_end_x, zone_end_y.
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   // zone_on_top.
   input  wire logic                                    req_tuser,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // Crossing point: cross_x, cross_y.
   output logic [sif_pkg::RSP_DATA_W-1:0]               rsp_tdata,
   // hit.
   output logic                                         rsp_tuser,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   input  wire logic                                    csr_we,
   input  wire logic [sif_pkg::CSR_AW-1:0]              csr_addr,
   input  wire logic [COORD_BITS-1:0]                   csr_wdata
);
   import sif_pkg::*;

   localparam int DB = 2 * COORD_BITS + 2;
   localparam int QB = COORD_BITS + FRAC_BITS + 1;
   localparam int WW = DB + QB;

   logic signed [COORD_BITS-1:0] qsx_ff, qsy_ff, qex_ff, qey_ff;
   logic                         qtop_ff;
   logic                         en;

   sif_ctl_type                  ctl   [QB+1];
   logic [DB-1:0]                den   [QB+1];
   logic [WW-1:0]                wx    [QB+1];
   logic [WW-1:0]                wy    [QB+1];

   logic [QB-1:0]                qx, qy;
   logic signed [QB:0]           sx, sy;
   logic [OUT_BITS-1:0]          cross_x_ff, cross_y_ff;

   // Query registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         qsx_ff  <= '0;
         qsy_ff  <= '0;
         qex_ff  <= '0;
         qey_ff  <= '0;
         qtop_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_QUERY_START_X: qsx_ff  <= csr_wdata;
            CSR_QUERY_START_Y: qsy_ff  <= csr_wdata;
            CSR_QUERY_END_X:   qex_ff  <= csr_wdata;
            CSR_QUERY_END_Y:   qey_ff  <= csr_wdata;
            CSR_QUERY_ON_TOP:  qtop_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or drains.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   sif_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .zsx       (req_tdata[COORD_BITS-1:0]),
      .zsy       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .zex       (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .zey       (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .zone_top  (req_tuser),
      .qsx       (qsx_ff),
      .qsy       (qsy_ff),
      .qex       (qex_ff),
      .qey       (qey_ff),
      .query_top (qtop_ff),
      .ctl_out   (ctl[0]),
      .den_out   (den[0]),
      .wx_out    (wx[0]),
      .wy_out    (wy[0])
   );

   // Divider chain, one quotient bit per cell.
   for (genvar gi = 0; gi < QB; gi++) begin : g_cell
      sif_div_cell #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl[gi]),
         .den_in  (den[gi]),
         .wx_in   (wx[gi]),
         .wy_in   (wy[gi]),
         .ctl_out (ctl[gi+1]),
         .den_out (den[gi+1]),
         .wx_out  (wx[gi+1]),
         .wy_out  (wy[gi+1])
      );
   end

   // Apply the sign to the quotients.
   assign qx = wx[QB][QB-1:0];
   assign qy = wy[QB][QB-1:0];
   assign sx = ctl[QB].neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
   assign sy = ctl[QB].neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         rsp_tvalid <= ctl[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tuser  <= ctl[QB].hit;
         cross_x_ff <= ctl[QB].hit ? OUT_BITS'(sx) : '0;
         cross_y_ff <= ctl[QB].hit ? OUT_BITS'(sy) : '0;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({cross_y_ff, cross_x_ff});

endmodule

`default_nettype wire

// ===== rtl/core/sif_checker.sv =====
// ----------------------------------------------------------------------------
// sif_checker
// Port-level checks of the segment intersection filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sif_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic [sif_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready
);
   import sif_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A miss always carries a zero crossing point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero coordinates");

   // Input is taken whenever the output side can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output side");

   // The pipeline is empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind segment_intersection_filter_unit sif_checker u_sif_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
